@@ hdl/two_light_diffuse_rgb555_shade_assert.svh @@
// Assertion macros shared by the shading block. They expect clk and rst_n in scope.
`ifndef TWO_LIGHT_DIFFUSE_RGB555_SHADE_ASSERT_SVH
`define TWO_LIGHT_DIFFUSE_RGB555_SHADE_ASSERT_SVH

// Same-cycle implication.
`define TLDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlds assertion failed");

// Next-cycle implication.
`define TLDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlds assertion failed");

`endif

@@ hdl/tlds_pkg.sv @@
`timescale 1ns / 1ps

package tlds_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DOT_W      = 19;  // positive 32-bit sum shifted right by 12
  localparam int ACC_W      = 17;  // 5-bit base plus two 15-bit terms
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [4:0] CH_MAX = 5'h1f;

  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT0_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT0_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT0_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT1_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT1_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT1_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE0   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE1   = 3'd7;

  typedef struct packed {
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        base_color;
  } in_item_t;

  typedef struct packed {
    logic [15:0] lit_color;
    logic [15:0] saved_color;
    logic [15:0] older_color;
  } out_item_t;

  // Work unit handed from front to back: normal plus unpacked channels.
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [4:0]         red;
    logic [4:0]         grn;
    logic [4:0]         blu;
  } task_t;

  typedef struct packed {
    logic signed [15:0] light0_x;
    logic signed [15:0] light0_y;
    logic signed [15:0] light0_z;
    logic signed [15:0] light1_x;
    logic signed [15:0] light1_y;
    logic signed [15:0] light1_z;
    logic [23:0]        scale0_rgb;
    logic [23:0]        scale1_rgb;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOT0,
    S_DOT1,
    S_SH0,
    S_SH1
  } seq_state_t;

  // Negative (bit 31 set) sums contribute nothing.
  function automatic logic [DOT_W-1:0] dot_clip(input logic [31:0] sum);
    dot_clip = sum[31] ? '0 : sum[FRAC_BITS+DOT_W-1:FRAC_BITS];
  endfunction

  function automatic logic [4:0] sat5(input logic [ACC_W-1:0] v);
    sat5 = (v > ACC_W'(CH_MAX)) ? CH_MAX : v[4:0];
  endfunction

endpackage

@@ hdl/tlds_fifo.sv @@
`timescale 1ns / 1ps
`include "two_light_diffuse_rgb555_shade_assert.svh"

module tlds_fifo
  import tlds_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_i,
  input  task_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output task_t data_o
);

  task_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  assign full_o  = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign empty_o = (count_r == '0);
  assign data_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  `TLDS_ASSERT_IMP(a_fifo_no_overflow, push_i && full_o, pop_i)
  `TLDS_ASSERT_IMP(a_fifo_no_underflow, pop_i, !empty_o)

endmodule

@@ hdl/tlds_front.sv @@
`timescale 1ns / 1ps

module tlds_front
  import tlds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  output logic     fwd_push_o,
  output task_t    fwd_task_o,
  input  logic     fwd_full_i
);

  logic  valid_r, valid_nxt;
  task_t task_r;
  logic  accept;

  assign fwd_push_o = valid_r && !fwd_full_i;
  assign fwd_task_o = task_r;
  // Takes a beat when empty or when the held one moves on this cycle.
  assign in_full    = valid_r && fwd_full_i;
  assign accept     = in_push && !in_full;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (fwd_push_o) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      task_r.nx  <= in_item.norm_x;
      task_r.ny  <= in_item.norm_y;
      task_r.nz  <= in_item.norm_z;
      task_r.red <= in_item.base_color[14:10];
      task_r.grn <= in_item.base_color[9:5];
      task_r.blu <= in_item.base_color[4:0];
    end
  end

endmodule

@@ hdl/tlds_back.sv @@
`timescale 1ns / 1ps
`include "two_light_diffuse_rgb555_shade_assert.svh"

module tlds_back
  import tlds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      fifo_empty,
  input  task_t     fifo_data,
  output logic      fifo_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  seq_state_t state_r, state_nxt;
  task_t      task_r;

  logic signed [19:0] mul_a [3];
  logic signed [16:0] mul_b [3];
  logic signed [36:0] mul_p [3];
  logic [31:0]        prod_r [3];
  logic [31:0]        psum;
  logic [DOT_W-1:0]   d0_r, d1_r;
  logic [ACC_W-1:0]   acc_r [3];
  logic [4:0]         base_ch [3];
  logic [4:0]         lit_ch [3];
  logic [15:0]        lit;
  logic               fin_v_r;
  logic               out_v_r;
  out_item_t          out_r;
  logic [15:0]        work_r, hist_r;
  logic               out_free;
  logic               sh1_done;
  logic               prod_en;

  assign out_free  = !out_v_r || out_pop;
  assign out_empty = !out_v_r;
  assign out_item  = out_r;

  assign base_ch[0] = task_r.red;
  assign base_ch[1] = task_r.grn;
  assign base_ch[2] = task_r.blu;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!fifo_empty) state_nxt = S_DOT0;
      S_DOT0: state_nxt = S_DOT1;
      S_DOT1: state_nxt = S_SH0;
      S_SH0:  state_nxt = S_SH1;
      S_SH1: begin
        if (out_free) state_nxt = fifo_empty ? S_IDLE : S_DOT0;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Three shared multipliers: dot terms in DOT0/DOT1, channel gains in SH0/SH1.
  always_comb begin
    fifo_pop = 1'b0;
    sh1_done = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mul_a[i] = '0;
      mul_b[i] = '0;
    end
    unique case (state_r)
      S_IDLE: fifo_pop = !fifo_empty;
      S_DOT0: begin
        mul_a[0] = 20'(cfg.light0_x);
        mul_a[1] = 20'(cfg.light0_y);
        mul_a[2] = 20'(cfg.light0_z);
        mul_b[0] = 17'(task_r.nx);
        mul_b[1] = 17'(task_r.ny);
        mul_b[2] = 17'(task_r.nz);
      end
      S_DOT1: begin
        mul_a[0] = 20'(cfg.light1_x);
        mul_a[1] = 20'(cfg.light1_y);
        mul_a[2] = 20'(cfg.light1_z);
        mul_b[0] = 17'(task_r.nx);
        mul_b[1] = 17'(task_r.ny);
        mul_b[2] = 17'(task_r.nz);
      end
      S_SH0: begin
        for (int i = 0; i < 3; i++) mul_a[i] = {1'b0, d0_r};
        mul_b[0] = {9'b0, cfg.scale0_rgb[23:16]};
        mul_b[1] = {9'b0, cfg.scale0_rgb[15:8]};
        mul_b[2] = {9'b0, cfg.scale0_rgb[7:0]};
      end
      S_SH1: begin
        for (int i = 0; i < 3; i++) mul_a[i] = {1'b0, d1_r};
        mul_b[0] = {9'b0, cfg.scale1_rgb[23:16]};
        mul_b[1] = {9'b0, cfg.scale1_rgb[15:8]};
        mul_b[2] = {9'b0, cfg.scale1_rgb[7:0]};
        sh1_done = out_free;
        fifo_pop = out_free && !fifo_empty;
      end
      default: fifo_pop = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) mul_p[i] = mul_a[i] * mul_b[i];
  end

  assign psum    = prod_r[0] + prod_r[1] + prod_r[2];
  // A stalled SH1 must keep the light 0 gain products for acc_r.
  assign prod_en = (state_r != S_SH1) || out_free;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lit_ch[i] = sat5(acc_r[i] + {2'b0, prod_r[i][FRAC_BITS+14:FRAC_BITS]});
    end
    lit = {work_r[15], lit_ch[0], lit_ch[1], lit_ch[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_v_r <= 1'b0;
      out_v_r <= 1'b0;
      work_r  <= '0;
      hist_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fin_v_r <= sh1_done;
      if (fin_v_r) begin
        out_v_r <= 1'b1;
        work_r  <= lit;
        hist_r  <= work_r;
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      task_r <= fifo_data;
    end
    if (prod_en) begin
      for (int i = 0; i < 3; i++) prod_r[i] <= mul_p[i][31:0];
    end
    if (state_r == S_DOT1) begin
      d0_r <= dot_clip(psum);
    end
    if (state_r == S_SH0) begin
      d1_r <= dot_clip(psum);
    end
    if (state_r == S_SH1) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= ACC_W'(base_ch[i]) + {2'b0, prod_r[i][FRAC_BITS+14:FRAC_BITS]};
      end
    end
    if (fin_v_r) begin
      out_r.lit_color   <= lit;
      out_r.saved_color <= work_r;
      out_r.older_color <= hist_r;
    end
  end

  `TLDS_ASSERT_IMP(a_fin_slot_free, fin_v_r, !out_v_r)
  `TLDS_ASSERT_NXT(a_sh1_stall_holds, state_r == S_SH1 && !out_free, state_r == S_SH1 && !fin_v_r)
  `TLDS_ASSERT_NXT(a_hist_follows_work, fin_v_r, hist_r == $past(work_r))
  `TLDS_ASSERT_IMP(a_pop_needs_data, fifo_pop, !fifo_empty)

endmodule

@@ hdl/two_light_diffuse_rgb555_shade.sv @@
`timescale 1ns / 1ps

// Two-light diffuse shader for RGB555 vertex colors. Each input beat carries a
// signed normal and a base color; for each light the 7.12 dot product is clipped
// at zero, scaled by that light's per-channel gain byte and added to the channels,
// which saturate at 31. One result beat per input: the new working color (bit 15
// carried over), the previous working color and the one before it. The back end's
// sequencer steps three shared multipliers through four passes (two dot-product
// passes, two gain passes) per item; a new item starts only after the last pass,
// which waits while the output register holds an unread result. Results pass
// the front register, two-entry queue, sequencer states DOT0 to SH1 and a finish
// stage into the output register. Configuration writes take effect on the next
// cycle and should only be issued while no item is in flight.
module two_light_diffuse_rgb555_shade
  import tlds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_item,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg_r, cfg_nxt;
  logic  fwd_push;
  task_t fwd_task;
  logic  fifo_full;
  logic  fifo_pop;
  logic  fifo_empty;
  task_t fifo_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIGHT0_X: cfg_nxt.light0_x   = cfg_wdata[15:0];
        CFG_LIGHT0_Y: cfg_nxt.light0_y   = cfg_wdata[15:0];
        CFG_LIGHT0_Z: cfg_nxt.light0_z   = cfg_wdata[15:0];
        CFG_LIGHT1_X: cfg_nxt.light1_x   = cfg_wdata[15:0];
        CFG_LIGHT1_Y: cfg_nxt.light1_y   = cfg_wdata[15:0];
        CFG_LIGHT1_Z: cfg_nxt.light1_z   = cfg_wdata[15:0];
        CFG_SCALE0:   cfg_nxt.scale0_rgb = cfg_wdata;
        CFG_SCALE1:   cfg_nxt.scale1_rgb = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tlds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_item    (in_item),
    .in_full    (in_full),
    .fwd_push_o (fwd_push),
    .fwd_task_o (fwd_task),
    .fwd_full_i (fifo_full)
  );

  tlds_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (fwd_push),
    .data_i  (fwd_task),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (fifo_data)
  );

  tlds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (fifo_empty),
    .fifo_data  (fifo_data),
    .fifo_pop   (fifo_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule

@@ test/two_light_diffuse_rgb555_shade_tb.sv @@
`timescale 1ns / 1ps

module two_light_diffuse_rgb555_shade_tb;
  import tlds_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int BLOCKS      = 13;
  localparam int BLOCK_ITEMS = 150;

  class shade_scoreboard;
    cfg_t        lights;
    logic [15:0] work_color;
    logic [15:0] hist_color;
    out_item_t   lit_queue[$];
    int          n_items;
    int          n_results;
    int          failures;

    function new();
      lights     = '0;
      work_color = '0;
      hist_color = '0;
      n_items    = 0;
      n_results  = 0;
      failures   = 0;
    endfunction

    function int pending();
      return lit_queue.size();
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LIGHT0_X: lights.light0_x = data[15:0];
        CFG_LIGHT0_Y: lights.light0_y = data[15:0];
        CFG_LIGHT0_Z: lights.light0_z = data[15:0];
        CFG_LIGHT1_X: lights.light1_x = data[15:0];
        CFG_LIGHT1_Y: lights.light1_y = data[15:0];
        CFG_LIGHT1_Z: lights.light1_z = data[15:0];
        CFG_SCALE0:   lights.scale0_rgb = data;
        CFG_SCALE1:   lights.scale1_rgb = data;
        default: ;
      endcase
    endfunction

    // 32-bit wrapping sum of three products; negative sums give zero
    function logic [18:0] beam_dot(input logic signed [15:0] cx, cy, cz, input in_item_t it);
      logic signed [31:0] px, py, pz;
      logic [31:0]        acc;
      px  = cx * $signed(it.norm_x);
      py  = cy * $signed(it.norm_y);
      pz  = cz * $signed(it.norm_z);
      acc = px + py + pz;
      return acc[31] ? 19'd0 : acc[30:12];
    endfunction

    function logic [31:0] gain_term(input logic [7:0] gain, input logic [18:0] d);
      return ({24'd0, gain} * {13'd0, d}) >> 12;
    endfunction

    function logic [4:0] clamp5(input logic [31:0] v);
      return (v > 32'd31) ? CH_MAX : v[4:0];
    endfunction

    function out_item_t shade(input in_item_t it);
      logic [18:0] d0, d1;
      logic [31:0] r, g, b;
      out_item_t   res;
      d0 = beam_dot(lights.light0_x, lights.light0_y, lights.light0_z, it);
      d1 = beam_dot(lights.light1_x, lights.light1_y, lights.light1_z, it);
      r = {27'd0, it.base_color[14:10]} + gain_term(lights.scale0_rgb[23:16], d0)
          + gain_term(lights.scale1_rgb[23:16], d1);
      g = {27'd0, it.base_color[9:5]} + gain_term(lights.scale0_rgb[15:8], d0)
          + gain_term(lights.scale1_rgb[15:8], d1);
      b = {27'd0, it.base_color[4:0]} + gain_term(lights.scale0_rgb[7:0], d0)
          + gain_term(lights.scale1_rgb[7:0], d1);
      res.lit_color   = {work_color[15], clamp5(r), clamp5(g), clamp5(b)};
      res.saved_color = work_color;
      res.older_color = hist_color;
      hist_color = work_color;
      work_color = res.lit_color;
      return res;
    endfunction

    function void note_input(input in_item_t it);
      lit_queue.push_back(shade(it));
      n_items++;
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      failures++;
    endtask

    task check_result(input out_item_t got);
      out_item_t want;
      if (lit_queue.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", got));
        return;
      end
      want = lit_queue.pop_front();
      n_results++;
      if (got.lit_color !== want.lit_color)
        report($sformatf("beat %0d lit_color %h, want %h", n_results, got.lit_color,
                         want.lit_color));
      if (got.saved_color !== want.saved_color)
        report($sformatf("beat %0d saved_color %h, want %h", n_results, got.saved_color,
                         want.saved_color));
      if (got.older_color !== want.older_color)
        report($sformatf("beat %0d older_color %h, want %h", n_results, got.older_color,
                         want.older_color));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  in_item_t              in_item = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  int settings_loaded = 0;

  shade_scoreboard sb = new();

  two_light_diffuse_rgb555_shade u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // one process for all sampling so config, inputs and results stay ordered
  always @(posedge clk) begin
    if (cfg_we)
      sb.set_reg(cfg_index, cfg_wdata);
    if (rst_n && in_push && !in_full)
      sb.note_input(in_item);
    if (rst_n && out_pop && !out_empty)
      sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("two_light_diffuse_rgb555_shade verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_beat(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // stop pushing, let every expected beat come out, then settle
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // junk in the upper byte of 16-bit registers must be dropped
  task automatic load_lights(input cfg_t c);
    put_reg(CFG_LIGHT0_X, {8'($urandom), c.light0_x});
    put_reg(CFG_LIGHT0_Y, {8'($urandom), c.light0_y});
    put_reg(CFG_LIGHT0_Z, {8'($urandom), c.light0_z});
    put_reg(CFG_LIGHT1_X, {8'($urandom), c.light1_x});
    put_reg(CFG_LIGHT1_Y, {8'($urandom), c.light1_y});
    put_reg(CFG_LIGHT1_Z, {8'($urandom), c.light1_z});
    put_reg(CFG_SCALE0, c.scale0_rgb);
    put_reg(CFG_SCALE1, c.scale1_rgb);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  function automatic cfg_t make_cfg(input logic [15:0] l0x, l0y, l0z, l1x, l1y, l1z,
                                    input logic [23:0] s0, s1);
    cfg_t c;
    c.light0_x = l0x;
    c.light0_y = l0y;
    c.light0_z = l0z;
    c.light1_x = l1x;
    c.light1_y = l1y;
    c.light1_z = l1z;
    c.scale0_rgb = s0;
    c.scale1_rgb = s1;
    return c;
  endfunction

  function automatic in_item_t mk_norm(input logic [15:0] x, y, z, base);
    in_item_t it;
    it.norm_x = x;
    it.norm_y = y;
    it.norm_z = z;
    it.base_color = base;
    return it;
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h1000;
      4: return 16'hf000;
      5: return 16'($urandom);
      default: return 16'($urandom_range(2047)) - 16'd1024;
    endcase
  endfunction

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(4))
      0: return 24'h000000;
      1: return 24'hffffff;
      2: return 24'($urandom);
      // low gains: only the low five bits of each channel byte are random
      default: return {3'b0, 5'($urandom), 3'b0, 5'($urandom), 3'b0, 5'($urandom)};
    endcase
  endfunction

  function automatic logic [15:0] pick_norm();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5, 6: return 16'($urandom);
      default: return 16'($urandom_range(16383)) - 16'd8192;
    endcase
  endfunction

  function automatic in_item_t random_item();
    return mk_norm(pick_norm(), pick_norm(), pick_norm(), 16'($urandom));
  endfunction

  function automatic cfg_t random_cfg();
    return make_cfg(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                    pick_coef(), pick_gain(), pick_gain());
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 84;

    // unit lights on +x and -z, full gain on light 0
    load_lights(make_cfg(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hf000,
                         24'hffffff, 24'h102040));
    push_beat(mk_norm(16'h0000, 16'h0000, 16'h0000, 16'h7fff));
    push_beat(mk_norm(16'h0000, 16'h0000, 16'h0000, 16'hffff));
    push_beat(mk_norm(16'h7fff, 16'h0000, 16'h0000, 16'h0000));
    push_beat(mk_norm(16'h8000, 16'h0000, 16'h0000, 16'h5294));
    push_beat(mk_norm(16'h0000, 16'h0000, 16'h8000, 16'h0421));
    push_beat(mk_norm(16'h0064, 16'h0000, 16'h0000, 16'h8000));
    push_beat(mk_norm(16'h0064, 16'h0000, 16'hfc00, 16'h7c1f));
    drain();

    // most negative coefficients: sums that wrap past bit 31 must add nothing
    load_lights(make_cfg(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000,
                         24'hffffff, 24'h0000ff));
    push_beat(mk_norm(16'h8000, 16'h8000, 16'h8000, 16'h0000));
    push_beat(mk_norm(16'h8000, 16'h8000, 16'h0000, 16'h03e0));
    push_beat(mk_norm(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    push_beat(mk_norm(16'h0001, 16'h0000, 16'h0000, 16'h1234));
    push_beat(mk_norm(16'hffff, 16'h0000, 16'h0000, 16'h0000));
    push_beat(mk_norm(16'hfff0, 16'h0000, 16'h0000, 16'h0000));
    drain();

    // most positive coefficients, small gains on light 0
    load_lights(make_cfg(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                         24'h010203, 24'h800000));
    push_beat(mk_norm(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000));
    push_beat(mk_norm(16'h7fff, 16'h7fff, 16'h0000, 16'h0000));
    push_beat(mk_norm(16'h0008, 16'h0000, 16'h0000, 16'h0000));
    push_beat(mk_norm(16'h0fff, 16'h0000, 16'h0000, 16'h0000));
    push_beat(mk_norm(16'h0fff, 16'h0000, 16'h0000, 16'h7c00));
    drain();

    for (int blk = 0; blk < BLOCKS; blk++) begin
      if (blk < 5) begin
        send_idle_pct = 35;
        recv_idle_pct = 84;
      end else if (blk < 10) begin
        send_idle_pct = 84;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_lights(random_cfg());
      repeat (BLOCK_ITEMS) push_beat(random_item());
      drain();
    end

    $display("shaded %0d normals, checked %0d lit colors across %0d light setups",
             sb.n_items, sb.n_results, settings_loaded);
    $display("flow control mixes: sender-heavy, receiver-heavy, free-running; %0d mismatches",
             sb.failures);
    if (sb.failures == 0) begin
      $display("two_light_diffuse_rgb555_shade verification clean");
    end else begin
      $display("two_light_diffuse_rgb555_shade verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tlds_pkg.sv
hdl/tlds_fifo.sv
hdl/tlds_front.sv
hdl/tlds_back.sv
hdl/two_light_diffuse_rgb555_shade.sv
test/two_light_diffuse_rgb555_shade_tb.sv
